### rtl/zcfm_pkg.sv
package zcfm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HYS_W      = 15;
    localparam int RATE_W     = 16;
    localparam int FREQ_W     = 24;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = 30;
    localparam int DIV_NUM_W  = 30;
    localparam int DIV_DEN_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH     = 2;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

    localparam logic [SAMPLE_W-1:0] ZERO_LEVEL_RST  = 16'd32768;
    localparam logic [HYS_W-1:0]    HYSTERESIS_RST  = 15'd1000;
    localparam logic [RATE_W-1:0]   SAMPLE_RATE_RST = 16'd8000;

    typedef struct packed {
        logic                start_req;
        logic [SAMPLE_W-1:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq_q8;
        logic [SAMPLE_W-1:0] period;
        logic                set_done;
        logic [FREQ_W-1:0]   avg_freq_q8;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] period;
        logic                first;
        logic                last;
    } t_job;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

### rtl/zcfm_fifo.sv
module zcfm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  zcfm_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output zcfm_pkg::t_job o_data,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(zcfm_pkg::QDEPTH);
    localparam int CNT_W = $clog2(zcfm_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(zcfm_pkg::QDEPTH);

    zcfm_pkg::t_job   r_mem [zcfm_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job queue underflow");

endmodule

### rtl/zcfm_front.sv
module zcfm_front #(
    parameter int SAMPLES_PER_SET = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  zcfm_pkg::t_in_item                 i_in_data,
    input  logic [zcfm_pkg::SAMPLE_W-1:0]      i_zero_level,
    input  logic [zcfm_pkg::HYS_W-1:0]         i_hysteresis,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output zcfm_pkg::t_job                     o_q_job
);

    localparam int IDX_W = $clog2(SAMPLES_PER_SET);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_SET - 1);
    localparam int SW = zcfm_pkg::SAMPLE_W;

    logic              r_active;
    logic              r_armed;
    logic [SW-1:0]     r_prev;
    logic [SW-1:0]     r_count;
    logic [IDX_W-1:0]  r_idx;

    logic              w_accept;
    logic [SW:0]       w_upper;
    logic signed [SW+1:0] w_lower;
    logic signed [SW+1:0] w_cur_s;
    logic signed [SW+1:0] w_prev_s;
    logic              w_rise;
    logic              w_fall;
    logic              w_last;

    assign w_accept = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    assign w_upper  = {1'b0, i_zero_level} + (SW+1)'(i_hysteresis);
    assign w_lower  = $signed((SW+2)'(i_zero_level)) - $signed((SW+2)'(i_hysteresis));
    assign w_cur_s  = $signed((SW+2)'(i_in_data.adc_sample));
    assign w_prev_s = $signed((SW+2)'(r_prev));

    assign w_rise = ({1'b0, i_in_data.adc_sample} >= w_upper) && ({1'b0, r_prev} < w_upper)
                    && r_armed;
    assign w_fall = !w_rise && (w_cur_s <= w_lower) && (w_prev_s > w_lower) && !r_armed;
    assign w_last = (r_idx == LAST_IDX);

    assign o_q_push       = w_accept && !i_in_data.start_req && r_active && w_fall;
    assign o_q_job.period = r_count;
    assign o_q_job.first  = (r_idx == '0);
    assign o_q_job.last   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_armed  <= 1'b0;
            r_prev   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
        end else if (w_accept) begin
            if (i_in_data.start_req) begin
                r_count  <= '0;
                r_idx    <= '0;
                r_active <= 1'b1;
            end else if (r_active) begin
                if (w_rise) begin
                    r_armed <= 1'b0;
                end else if (w_fall) begin
                    r_armed <= 1'b1;
                    if (w_last) begin
                        r_idx    <= '0;
                        r_active <= 1'b0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                r_prev <= i_in_data.adc_sample;
                if (w_fall) begin
                    r_count <= SW'(1);
                end else if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

endmodule

### rtl/zcfm_div.sv
module zcfm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zcfm_pkg::t_div_req i_req,
    output zcfm_pkg::t_div_rsp o_rsp
);

    localparam int NW    = zcfm_pkg::DIV_NUM_W;
    localparam int DW    = zcfm_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;

    logic [DW:0]      w_rem_sh;
    logic             w_ge;
    logic [DW:0]      w_diff;

    assign w_rem_sh = {r_rem, r_quo[NW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW - 1);
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

### rtl/zcfm_back.sv
module zcfm_back #(
    parameter int SAMPLES_PER_SET = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [zcfm_pkg::RATE_W-1:0]   i_sample_rate,
    input  logic                          i_q_empty,
    input  zcfm_pkg::t_job                i_q_job,
    output logic                          o_q_pop,
    output zcfm_pkg::t_div_req            o_div_req,
    input  zcfm_pkg::t_div_rsp            i_div_rsp,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output zcfm_pkg::t_out_item           o_out_data
);

    localparam logic [zcfm_pkg::DIV_DEN_W-1:0] AVG_DEN =
        zcfm_pkg::DIV_DEN_W'(SAMPLES_PER_SET - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVF,
        S_ACC,
        S_DIVA,
        S_EMIT
    } t_state;

    t_state                          r_state;
    zcfm_pkg::t_job                  r_job;
    logic [zcfm_pkg::FREQ_W-1:0]     r_freq;
    logic [zcfm_pkg::FREQ_W-1:0]     r_avg;
    logic [zcfm_pkg::SUM_W-1:0]      r_sum;
    zcfm_pkg::t_div_req              r_div_req;
    logic                            r_out_valid;
    zcfm_pkg::t_out_item             r_out;

    logic [zcfm_pkg::SUM_W-1:0]      w_sum;

    assign w_sum = r_job.first ? '0 : r_sum + zcfm_pkg::SUM_W'(r_freq);

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_div_req   = r_div_req;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job <= i_q_job;
                        if (i_q_job.period == '0) begin
                            r_freq  <= zcfm_pkg::FREQ_MAX;
                            r_state <= S_ACC;
                        end else begin
                            r_div_req.start <= 1'b1;
                            r_div_req.num   <= zcfm_pkg::DIV_NUM_W'({i_sample_rate,
                                               zcfm_pkg::FRAC_W'(0)});
                            r_div_req.den   <= i_q_job.period;
                            r_state         <= S_DIVF;
                        end
                    end
                end
                S_DIVF: begin
                    if (i_div_rsp.done) begin
                        r_freq  <= i_div_rsp.quo[zcfm_pkg::FREQ_W-1:0];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum <= w_sum;
                    if (r_job.last) begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= zcfm_pkg::DIV_NUM_W'(w_sum);
                        r_div_req.den   <= AVG_DEN;
                        r_state         <= S_DIVA;
                    end else begin
                        r_avg   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_DIVA: begin
                    if (i_div_rsp.done) begin
                        r_avg   <= i_div_rsp.quo[zcfm_pkg::FREQ_W-1:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.freq_q8     <= r_freq;
                        r_out.period      <= r_job.period;
                        r_out.set_done    <= r_job.last;
                        r_out.avg_freq_q8 <= r_avg;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_req.start |-> !i_div_rsp.busy) else $error("divider started while busy");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_DIVF || r_state == S_DIVA))
        else $error("divider result with nobody waiting");

    a_avg_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.set_done) |-> (r_out.avg_freq_q8 == '0))
        else $error("average reported outside set end");

endmodule

### rtl/zero_crossing_frequency_meter.sv
// Zero-crossing frequency meter.
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat per ADC sample, or a
// start request that clears the set and activates the meter. Samples arriving while not
// active are dropped without a result.
// Output channel (o_out_valid / i_out_stall / o_out_data): one beat per falling crossing
// with frequency (Q16.8 Hz), period in samples, and on the last crossing of the set the
// set_done flag and the average frequency of all crossings but the first.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): always ready;
// index 0 zero level, 1 hysteresis, 2 sample rate. Write only while idle.
// Flow: the back end handles one queued crossing at a time and must finish it before it
// pops another; its frequency comes from the 30-step serial divider, the last crossing
// of a set runs the divider twice, and a zero period skips the divider. A two-beat job
// queue lets the front keep taking samples meanwhile; the front stalls only when the
// queue is full.
// Reset clears all control state, disarms the meter and loads the default registers.
// When the receiver stalls, the result holds in the output register, the back end
// finishes its next job and waits, and the queue fills before the input stalls.
module zero_crossing_frequency_meter #(
    parameter int SAMPLES_PER_SET = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  zcfm_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output zcfm_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [zcfm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [zcfm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [zcfm_pkg::SAMPLE_W-1:0] r_zero_level;
    logic [zcfm_pkg::HYS_W-1:0]    r_hysteresis;
    logic [zcfm_pkg::RATE_W-1:0]   r_sample_rate;

    logic                w_q_full;
    logic                w_q_empty;
    logic                w_q_push;
    logic                w_q_pop;
    zcfm_pkg::t_job      w_push_job;
    zcfm_pkg::t_job      w_pop_job;
    zcfm_pkg::t_div_req  w_div_req;
    zcfm_pkg::t_div_rsp  w_div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_level  <= zcfm_pkg::ZERO_LEVEL_RST;
            r_hysteresis  <= zcfm_pkg::HYSTERESIS_RST;
            r_sample_rate <= zcfm_pkg::SAMPLE_RATE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                zcfm_pkg::CFG_ZERO_LEVEL:  r_zero_level  <= i_cfg_data;
                zcfm_pkg::CFG_HYSTERESIS:  r_hysteresis  <= i_cfg_data[zcfm_pkg::HYS_W-1:0];
                zcfm_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    zcfm_front #(
        .SAMPLES_PER_SET(SAMPLES_PER_SET)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_zero_level (r_zero_level),
        .i_hysteresis (r_hysteresis),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_job      (w_push_job)
    );

    zcfm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_pop_job),
        .o_empty (w_q_empty)
    );

    zcfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    zcfm_back #(
        .SAMPLES_PER_SET(SAMPLES_PER_SET)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample_rate (r_sample_rate),
        .i_q_empty     (w_q_empty),
        .i_q_job       (w_pop_job),
        .o_q_pop       (w_q_pop),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule
